[hw/rtl/tbt_pkg.sv]
// Shared constants and types for the tangent/bitangent unit.
package tbt_pkg;

   // Slots of the per-triangle delta bundle passed from front to back.
   typedef enum logic [3:0] {
      D_Q1X = 4'd0,
      D_Q1Y = 4'd1,
      D_Q1Z = 4'd2,
      D_Q2X = 4'd3,
      D_Q2Y = 4'd4,
      D_Q2Z = 4'd5,
      D_U1  = 4'd6,
      D_V1  = 4'd7,
      D_U2  = 4'd8,
      D_V2  = 4'd9
   } delta_idx_type;

   localparam int NUM_DELTAS = 10;
   localparam int NUM_COMPS  = 6;

endpackage

[hw/rtl/tbt_front.sv]
// Corner collector: holds two corners, forms the triangle deltas on the third.
module tbt_front #(
   parameter int COORD_BITS = 32,
   parameter int DW         = COORD_BITS + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             acc_valid,
   input  logic [COORD_BITS-1:0]            pos_x,
   input  logic [COORD_BITS-1:0]            pos_y,
   input  logic [COORD_BITS-1:0]            pos_z,
   input  logic [COORD_BITS-1:0]            tex_s,
   input  logic [COORD_BITS-1:0]            tex_t,
   output logic                             tri_push,
   output logic [tbt_pkg::NUM_DELTAS*DW-1:0] tri_data
);

   logic [1:0]            count_ff, count_in;
   logic [COORD_BITS-1:0] hx_ff [2];
   logic [COORD_BITS-1:0] hy_ff [2];
   logic [COORD_BITS-1:0] hz_ff [2];
   logic [COORD_BITS-1:0] hs_ff [2];
   logic [COORD_BITS-1:0] ht_ff [2];

   function automatic logic [DW-1:0] sdiff(input logic [COORD_BITS-1:0] a,
                                           input logic [COORD_BITS-1:0] b);
      sdiff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
   endfunction

   assign tri_push = acc_valid && (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      if (acc_valid) begin
         count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      if (acc_valid && count_ff != 2'd2) begin
         hx_ff[count_ff[0]] <= pos_x;
         hy_ff[count_ff[0]] <= pos_y;
         hz_ff[count_ff[0]] <= pos_z;
         hs_ff[count_ff[0]] <= tex_s;
         ht_ff[count_ff[0]] <= tex_t;
      end
   end

   always_comb begin
      tri_data = '0;
      tri_data[int'(tbt_pkg::D_Q1X)*DW +: DW] = sdiff(hx_ff[1], hx_ff[0]);
      tri_data[int'(tbt_pkg::D_Q1Y)*DW +: DW] = sdiff(hy_ff[1], hy_ff[0]);
      tri_data[int'(tbt_pkg::D_Q1Z)*DW +: DW] = sdiff(hz_ff[1], hz_ff[0]);
      tri_data[int'(tbt_pkg::D_Q2X)*DW +: DW] = sdiff(pos_x, hx_ff[0]);
      tri_data[int'(tbt_pkg::D_Q2Y)*DW +: DW] = sdiff(pos_y, hy_ff[0]);
      tri_data[int'(tbt_pkg::D_Q2Z)*DW +: DW] = sdiff(pos_z, hz_ff[0]);
      tri_data[int'(tbt_pkg::D_U1)*DW +: DW]  = sdiff(hs_ff[1], hs_ff[0]);
      tri_data[int'(tbt_pkg::D_V1)*DW +: DW]  = sdiff(ht_ff[1], ht_ff[0]);
      tri_data[int'(tbt_pkg::D_U2)*DW +: DW]  = sdiff(tex_s, hs_ff[0]);
      tri_data[int'(tbt_pkg::D_V2)*DW +: DW]  = sdiff(tex_t, ht_ff[0]);
   end

endmodule

[hw/rtl/tbt_queue.sv]
// Two-entry queue of triangle delta bundles between front and back.
module tbt_queue #(
   parameter int WIDTH = 330
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 2'd1;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

[hw/rtl/tbt_back.sv]
// Triangle math: determinant, six numerators, bit-serial divide, round and saturate.
module tbt_back #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16,
   parameter int DW         = COORD_BITS + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             tri_empty,
   input  logic [tbt_pkg::NUM_DELTAS*DW-1:0] tri_data,
   output logic                             tri_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [COORD_BITS-1:0]            rsp_tan_x,
   output logic [COORD_BITS-1:0]            rsp_tan_y,
   output logic [COORD_BITS-1:0]            rsp_tan_z,
   output logic [COORD_BITS-1:0]            rsp_bit_x,
   output logic [COORD_BITS-1:0]            rsp_bit_y,
   output logic [COORD_BITS-1:0]            rsp_bit_z,
   output logic                             rsp_degenerate
);

   localparam int PRW = 2 * DW;
   localparam int PW  = PRW + 1;
   localparam int NW  = PW + FRAC_BITS;
   localparam int CW  = $clog2(NW);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_ABS, S_DIV, S_RND, S_DONE
   } state_type;

   state_type              state_ff;
   logic [DW-1:0]          dl_ff [tbt_pkg::NUM_DELTAS];
   logic                   det_ph_ff;
   logic [2:0]             comp_ff;
   logic signed [PRW-1:0]  prod_ff;
   logic signed [PW-1:0]   acc_ff;
   logic                   den_neg_ff, num_neg_ff;
   logic [PW-1:0]          den_ff;
   logic [NW-1:0]          n_ff, q_ff;
   logic [PW:0]            rem_ff;
   logic [CW-1:0]          bit_ff;
   logic [COORD_BITS-1:0]  res_ff [tbt_pkg::NUM_COMPS];
   logic                   degen_ff;
   logic                   out_valid_ff;

   logic [DW-1:0]          op_a, op_b, op_c, op_d, m_x, m_y;
   logic signed [PRW-1:0]  m_p;
   logic signed [PW-1:0]   acc_next;
   logic [PW-1:0]          acc_mag;
   logic [PW:0]            rem_sh, rem_sub;
   logic [NW:0]            q_rnd;
   logic [NW:0]            lim;
   logic [COORD_BITS-1:0]  mag, res_val;
   logic                   load_out;

   // Operand pairs: det = u1*v2 - u2*v1; tangent = v2*q1 - v1*q2;
   // bitangent = u1*q2 - u2*q1.
   always_comb begin
      op_a = dl_ff[tbt_pkg::D_U1];
      op_b = dl_ff[tbt_pkg::D_V2];
      op_c = dl_ff[tbt_pkg::D_U2];
      op_d = dl_ff[tbt_pkg::D_V1];
      if (!det_ph_ff) begin
         case (comp_ff)
            3'd0: begin
               op_a = dl_ff[tbt_pkg::D_V2]; op_b = dl_ff[tbt_pkg::D_Q1X];
               op_c = dl_ff[tbt_pkg::D_V1]; op_d = dl_ff[tbt_pkg::D_Q2X];
            end
            3'd1: begin
               op_a = dl_ff[tbt_pkg::D_V2]; op_b = dl_ff[tbt_pkg::D_Q1Y];
               op_c = dl_ff[tbt_pkg::D_V1]; op_d = dl_ff[tbt_pkg::D_Q2Y];
            end
            3'd2: begin
               op_a = dl_ff[tbt_pkg::D_V2]; op_b = dl_ff[tbt_pkg::D_Q1Z];
               op_c = dl_ff[tbt_pkg::D_V1]; op_d = dl_ff[tbt_pkg::D_Q2Z];
            end
            3'd3: begin
               op_a = dl_ff[tbt_pkg::D_U1]; op_b = dl_ff[tbt_pkg::D_Q2X];
               op_c = dl_ff[tbt_pkg::D_U2]; op_d = dl_ff[tbt_pkg::D_Q1X];
            end
            3'd4: begin
               op_a = dl_ff[tbt_pkg::D_U1]; op_b = dl_ff[tbt_pkg::D_Q2Y];
               op_c = dl_ff[tbt_pkg::D_U2]; op_d = dl_ff[tbt_pkg::D_Q1Y];
            end
            3'd5: begin
               op_a = dl_ff[tbt_pkg::D_U1]; op_b = dl_ff[tbt_pkg::D_Q2Z];
               op_c = dl_ff[tbt_pkg::D_U2]; op_d = dl_ff[tbt_pkg::D_Q1Z];
            end
            default: ;
         endcase
      end
      m_x = (state_ff == S_MUL0) ? op_a : op_c;
      m_y = (state_ff == S_MUL0) ? op_b : op_d;
   end

   assign m_p      = $signed(m_x) * $signed(m_y);
   assign acc_next = acc_ff - PW'(prod_ff);
   assign acc_mag  = acc_ff[PW-1] ? PW'(-acc_ff) : PW'(acc_ff);
   assign rem_sh   = {rem_ff[PW-1:0], n_ff[NW-1]};
   assign rem_sub  = rem_sh - {1'b0, den_ff};

   // Round half away from zero on magnitudes, then clamp.
   always_comb begin
      q_rnd = {1'b0, q_ff};
      if ({rem_ff[PW-1:0], 1'b0} >= {1'b0, den_ff}) q_rnd = {1'b0, q_ff} + (NW+1)'(1);
      lim = (NW+1)'(1) << (COORD_BITS - 1);
      if (!(num_neg_ff ^ den_neg_ff)) lim = lim - (NW+1)'(1);
      mag     = (q_rnd > lim) ? lim[COORD_BITS-1:0] : q_rnd[COORD_BITS-1:0];
      res_val = (num_neg_ff ^ den_neg_ff) ? -mag : mag;
   end

   assign tri_pop   = (state_ff == S_IDLE) && !tri_empty;
   assign rsp_empty = !out_valid_ff;
   assign load_out  = (state_ff == S_DONE) && (!out_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         det_ph_ff    <= 1'b1;
         comp_ff      <= 3'd0;
      end else begin
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!tri_empty) begin
                  for (int i = 0; i < tbt_pkg::NUM_DELTAS; i++) begin
                     dl_ff[i] <= tri_data[i*DW +: DW];
                  end
                  det_ph_ff <= 1'b1;
                  comp_ff   <= 3'd0;
                  degen_ff  <= 1'b0;
                  state_ff  <= S_MUL0;
               end
            end
            S_MUL0: begin
               prod_ff  <= m_p;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               acc_ff   <= PW'(prod_ff);
               prod_ff  <= m_p;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= acc_next;
               state_ff <= S_ABS;
            end
            S_ABS: begin
               if (det_ph_ff) begin
                  den_neg_ff <= acc_ff[PW-1];
                  den_ff     <= acc_mag;
                  det_ph_ff  <= 1'b0;
                  comp_ff    <= 3'd0;
                  if (acc_ff == '0) begin
                     degen_ff <= 1'b1;
                     for (int i = 0; i < tbt_pkg::NUM_COMPS; i++) res_ff[i] <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_MUL0;
                  end
               end else begin
                  num_neg_ff <= acc_ff[PW-1];
                  n_ff       <= NW'(acc_mag) << FRAC_BITS;
                  rem_ff     <= '0;
                  q_ff       <= '0;
                  bit_ff     <= CW'(NW - 1);
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               n_ff <= n_ff << 1;
               if (!rem_sub[PW]) begin
                  rem_ff <= rem_sub;
                  q_ff   <= {q_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  q_ff   <= {q_ff[NW-2:0], 1'b0};
               end
               bit_ff <= bit_ff - CW'(1);
               if (bit_ff == '0) state_ff <= S_RND;
            end
            S_RND: begin
               res_ff[comp_ff] <= res_val;
               if (comp_ff == 3'(tbt_pkg::NUM_COMPS - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  comp_ff  <= comp_ff + 3'd1;
                  state_ff <= S_MUL0;
               end
            end
            S_DONE: begin
               if (load_out) begin
                  rsp_tan_x      <= res_ff[0];
                  rsp_tan_y      <= res_ff[1];
                  rsp_tan_z      <= res_ff[2];
                  rsp_bit_x      <= res_ff[3];
                  rsp_bit_y      <= res_ff[4];
                  rsp_bit_z      <= res_ff[5];
                  rsp_degenerate <= degen_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/triangle_tangent_bitangent_top.sv]
// Top level of the triangle tangent/bitangent unit.
// Corners: one transaction per cycle while the two-deep triangle queue has room.
// Triangle math: one shared unit forms the determinant, then runs the bit-serial divider for
// each of the six components in turn, so the back end takes a new triangle only once the last
// is through (results are Q16.16 with the defaults); a degenerate triangle skips the divides.
// Synchronous active-high reset empties the queue, the collector and the result slot.
module triangle_tangent_bitangent_top #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_pos_z,
   input  logic [COORD_BITS-1:0] req_tex_s,
   input  logic [COORD_BITS-1:0] req_tex_t,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_tan_x,
   output logic [COORD_BITS-1:0] rsp_tan_y,
   output logic [COORD_BITS-1:0] rsp_tan_z,
   output logic [COORD_BITS-1:0] rsp_bit_x,
   output logic [COORD_BITS-1:0] rsp_bit_y,
   output logic [COORD_BITS-1:0] rsp_bit_z,
   output logic                  rsp_degenerate
);

   // Deltas are one bit wider than the coordinates so differences are exact.
   localparam int DW = COORD_BITS + 1;
   localparam int QW = tbt_pkg::NUM_DELTAS * DW;

   logic          q_full, q_empty, q_push, q_pop;
   logic [QW-1:0] q_in, q_out;

   // Every corner is held off while the queue is full.
   assign req_full = q_full;

   tbt_front #(.COORD_BITS(COORD_BITS), .DW(DW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .acc_valid (req_push && !q_full),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .tex_s     (req_tex_s),
      .tex_t     (req_tex_t),
      .tri_push  (q_push),
      .tri_data  (q_in)
   );

   // Short queue lets the collector keep taking corners while the back end divides.
   tbt_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   // Back end owns the result register, so it can start the next triangle
   // only once the previous result has moved into it.
   tbt_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .tri_empty      (q_empty),
      .tri_data       (q_out),
      .tri_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tan_x      (rsp_tan_x),
      .rsp_tan_y      (rsp_tan_y),
      .rsp_tan_z      (rsp_tan_z),
      .rsp_bit_x      (rsp_bit_x),
      .rsp_bit_y      (rsp_bit_y),
      .rsp_bit_z      (rsp_bit_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

[sim/triangle_tangent_bitangent_top_test.sv]
// Self-checking testbench for the triangle tangent/bitangent unit.
`timescale 1ns / 1ps

module triangle_tangent_bitangent_top_test;

   localparam int CB         = 32;
   localparam int FB         = 16;
   localparam int QUIET_LIM  = 20000;  // cycles without any transaction before giving up
   localparam int TAIL_WAIT  = 1000;   // covers one full triangle of divider work
   localparam int RANDOM_TRI = 667;    // ~2000 corners
   localparam int CALM_TAIL  = 150;    // corners left when idling stops

   typedef struct {
      logic [CB-1:0] x, y, z, s, t;
      bit            drain;            // hold off until every frame is back
   } corner_type;

   typedef struct {
      logic [CB-1:0] tx, ty, tz, bx, by, bz;
      logic          degen;
   } frame_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   logic [CB-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [CB-1:0] req_tex_s = '0, req_tex_t = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   logic [CB-1:0] rsp_tan_x, rsp_tan_y, rsp_tan_z, rsp_bit_x, rsp_bit_y, rsp_bit_z;
   logic          rsp_degenerate;

   corner_type corner_queue[$];        // corners still to be sent
   frame_type  frame_queue[$];         // predicted frames awaiting the unit
   corner_type on_bus;                 // corner currently offered
   corner_type held[2];                // predictor copy of the first two corners
   int      held_count = 0;
   int      send_idle  = 0;
   int      recv_idle  = 0;
   int      quiet      = 0;
   int      fails      = 0;

   triangle_tangent_bitangent_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
      .clock, .reset, .req_push, .req_full,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_tex_s, .req_tex_t,
      .rsp_empty, .rsp_pop,
      .rsp_tan_x, .rsp_tan_y, .rsp_tan_z, .rsp_bit_x, .rsp_bit_y, .rsp_bit_z,
      .rsp_degenerate
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor: exact products, rounded quotient with ties away from zero
   // ---------------------------------------------------------------------------
   function automatic longint sx(logic [CB-1:0] v);
      sx = $signed(v);
   endfunction

   function automatic logic signed [127:0] cross_diff(longint a, longint b,
                                                      longint c, longint d);
      logic signed [127:0] wa, wb, wc, wd;
      wa = a; wb = b; wc = c; wd = d;
      cross_diff = wa * wb - wc * wd;
   endfunction

   function automatic logic [CB-1:0] fix_div(logic signed [127:0] num,
                                              logic signed [127:0] den);
      logic [127:0] n, d, q, r, lim;
      bit neg;
      neg = num[127] ^ den[127];
      n   = num[127] ? -num : num;
      d   = den[127] ? -den : den;
      n   = n << FB;
      q   = n / d;
      r   = n % d;
      if ((r << 1) >= d) q = q + 1;
      lim = neg ? (128'd1 << (CB - 1)) : (128'd1 << (CB - 1)) - 1;
      if (q > lim) q = lim;
      fix_div = neg ? -q[CB-1:0] : q[CB-1:0];
   endfunction

   // Third corner closes the triangle; corner 1 is the origin.
   function automatic frame_type tangent_frame(corner_type c1, corner_type c2,
                                               corner_type c3);
      frame_type f;
      longint q1[3], q2[3];
      longint u1, v1, u2, v2;
      logic signed [127:0] det;
      q1[0] = sx(c2.x) - sx(c1.x); q2[0] = sx(c3.x) - sx(c1.x);
      q1[1] = sx(c2.y) - sx(c1.y); q2[1] = sx(c3.y) - sx(c1.y);
      q1[2] = sx(c2.z) - sx(c1.z); q2[2] = sx(c3.z) - sx(c1.z);
      u1 = sx(c2.s) - sx(c1.s); v1 = sx(c2.t) - sx(c1.t);
      u2 = sx(c3.s) - sx(c1.s); v2 = sx(c3.t) - sx(c1.t);
      det = cross_diff(u1, v2, u2, v1);
      f = '{default: '0};
      if (det == 0) begin
         f.degen = 1'b1;
      end else begin
         f.tx = fix_div(cross_diff(v2, q1[0], v1, q2[0]), det);
         f.ty = fix_div(cross_diff(v2, q1[1], v1, q2[1]), det);
         f.tz = fix_div(cross_diff(v2, q1[2], v1, q2[2]), det);
         f.bx = fix_div(cross_diff(u1, q2[0], u2, q1[0]), det);
         f.by = fix_div(cross_diff(u1, q2[1], u2, q1[1]), det);
         f.bz = fix_div(cross_diff(u1, q2[2], u2, q1[2]), det);
      end
      return f;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic corner_type mk(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                                     logic [CB-1:0] s, logic [CB-1:0] t);
      corner_type c;
      c.x = x; c.y = y; c.z = z; c.s = s; c.t = t; c.drain = 1'b0;
      return c;
   endfunction

   function automatic logic [CB-1:0] near(logic [CB-1:0] base, int span);
      near = base + $urandom_range(2 * span) - span;
   endfunction

   function automatic corner_type rand_corner();
      return mk($urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic add_tri(corner_type a, corner_type b, corner_type c);
      corner_queue.insert(corner_queue.size(), a);
      corner_queue.insert(corner_queue.size(), b);
      corner_queue.insert(corner_queue.size(), c);
   endtask

   // One random triangle, picked from several shapes
   task automatic add_random_tri();
      corner_type a, b, c;
      logic [CB-1:0] bs, bt;
      int pick, span;
      pick = $urandom_range(99);
      a = rand_corner(); b = rand_corner(); c = rand_corner();
      if (pick < 30) begin
         // fully random: every bit toggles, results mostly small
      end else if (pick < 60) begin
         // compact triangle, moderate texture deltas: ordinary frames
         span = 1 << $urandom_range(4, 20);
         b = mk(near(a.x, span), near(a.y, span), near(a.z, span),
                near(a.s, span), near(a.t, span));
         c = mk(near(a.x, span), near(a.y, span), near(a.z, span),
                near(a.s, span), near(a.t, span));
      end else if (pick < 75) begin
         // tiny texture spread under large positions: saturation
         b.s = near(a.s, 3); b.t = near(a.t, 3);
         c.s = near(a.s, 3); c.t = near(a.t, 3);
      end else if (pick < 90) begin
         // collinear texture coordinates: zero determinant
         bs = b.s - a.s; bt = b.t - a.t;
         case ($urandom_range(2))
            0: begin c.s = a.s; c.t = a.t; end
            1: begin c.s = b.s; c.t = b.t; end
            default: begin c.s = a.s - bs; c.t = a.t - bt; end
         endcase
         if ($urandom_range(1)) begin b.s = a.s; b.t = a.t; end
      end else begin
         // determinant 2^17 with odd deltas: exact half-way rounding
         b = mk(a.x + ($urandom_range(63) | 1) - 32, a.y + $urandom_range(63) - 32,
                a.z + ($urandom_range(63) | 1) - 32, a.s + 32'h0002_0000, a.t);
         c = mk($urandom, $urandom, $urandom, a.s, a.t + 1);
      end
      add_tri(a, b, c);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers queued corners, predicts on every accepted transaction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      bit fire;
      fire = req_push && !req_full;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (fire) begin
            quiet_note();
            if (held_count < 2) begin
               held[held_count] = on_bus;
               held_count++;
            end else begin
               frame_queue.insert(frame_queue.size(),
                                  tangent_frame(held[0], held[1], on_bus));
               held_count = 0;
            end
         end
         if (req_push && !fire) begin
            // keep offering the same corner while the unit is full
         end else if (send_idle > 0) begin
            send_idle--;
            req_push <= 1'b0;
         end else if (corner_queue.size() > CALM_TAIL && $urandom_range(7) == 0) begin
            send_idle = $urandom_range(0, 8);
            req_push <= 1'b0;
         end else if (corner_queue.size() == 0 ||
                      (corner_queue[0].drain && frame_queue.size() != 0)) begin
            req_push <= 1'b0;
         end else begin
            on_bus = corner_queue.pop_front();
            req_pos_x <= on_bus.x; req_pos_y <= on_bus.y; req_pos_z <= on_bus.z;
            req_tex_s <= on_bus.s; req_tex_t <= on_bus.t;
            req_push  <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random pop stalls, field-by-field compare against oldest frame
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_type exp_f;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            quiet_note();
            if (frame_queue.size() == 0) begin
               $error("unexpected result transaction");
               fails++;
            end else begin
               exp_f = frame_queue.pop_front();
               check_field("tan_x", exp_f.tx, rsp_tan_x);
               check_field("tan_y", exp_f.ty, rsp_tan_y);
               check_field("tan_z", exp_f.tz, rsp_tan_z);
               check_field("bit_x", exp_f.bx, rsp_bit_x);
               check_field("bit_y", exp_f.by, rsp_bit_y);
               check_field("bit_z", exp_f.bz, rsp_bit_z);
               check_field("degenerate", CB'(exp_f.degen), CB'(rsp_degenerate));
            end
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_pop <= 1'b0;
         end else if (corner_queue.size() > CALM_TAIL && $urandom_range(5) == 0) begin
            recv_idle = $urandom_range(0, 8);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic check_field(string name, logic [CB-1:0] exp_v, logic [CB-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         fails++;
      end
   endtask

   // Flags that some transaction happened this cycle
   bit moved;
   task automatic quiet_note();
      moved = 1'b1;
   endtask

   // Watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      #1;
      if (reset || moved) quiet = 0;
      else quiet++;
      moved = 1'b0;
      if (quiet >= QUIET_LIM) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: directed triangles, a drain point, random triangles, wind-down
   // ---------------------------------------------------------------------------
   initial begin
      corner_type c;
      // all-zero triangle: degenerate
      add_tri(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0));
      // unit right triangle
      add_tri(mk(0, 0, 0, 0, 0), mk(32'h0001_0000, 0, 0, 32'h0001_0000, 0),
              mk(0, 32'h0001_0000, 0, 0, 32'h0001_0000));
      // smallest determinant under extreme positions: saturates both ways
      add_tri(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0),
              mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0),
              mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 1));
      // field extremes on every input
      add_tri(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000),
              mk(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      // collinear texture, nonzero positions: degenerate
      add_tri(mk(5, 6, 7, 32'h0001_0000, 32'h0002_0000),
              mk(32'h0010_0000, 9, 10, 32'h0002_0000, 32'h0003_0000),
              mk(11, 32'h0020_0000, 13, 32'h0003_0000, 32'h0004_0000));
      // exact half-way quotients of both signs: rounds away from zero
      add_tri(mk(0, 0, 0, 0, 0), mk(1, -1, 3, 32'h0002_0000, 0), mk(0, 0, 0, 0, 1));
      // pause here until everything so far has come back
      c = mk(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'h0000_1000, 32'h0000_2000);
      c.drain = 1'b1;
      add_tri(c, mk(32'h1234_0000, 32'h9ABC_0000, 32'h0F0F_0000, 32'h0000_3000, 32'h0000_1000),
              mk(32'h1200_0000, 32'h9A00_0000, 32'h0F00_0000, 32'h0000_0800, 32'h0000_4000));
      for (int i = 0; i < RANDOM_TRI; i++) begin
         add_random_tri();
         if (i == RANDOM_TRI / 2) corner_queue[corner_queue.size() - 3].drain = 1'b1;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (corner_queue.size() == 0 && !req_push);
      wait (frame_queue.size() == 0);
      repeat (TAIL_WAIT) @(posedge clock);

      if (fails == 0 && frame_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
